// ===== design/hsl_pkg.sv =====
// shared types, widths and the restoring divide step for the rgb to hsl converter
// no dependencies
`default_nettype none

package hsl_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumW   = 17;
  localparam int unsigned DenW   = 9;
  localparam int unsigned TermW  = 11;
  localparam int unsigned DivStg = 4;
  localparam int unsigned BitsPerStg = 2;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [NumW-1:0]  hrem;
    logic [DenW-1:0]  hden;
    logic [ChanW-1:0] hq;
    logic [NumW-1:0]  srem;
    logic [DenW-1:0]  sden;
    logic [ChanW-1:0] sq;
    logic             grey;
    logic [ChanW-1:0] light;
  } div_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [NumW:0] div_step(input logic [NumW-1:0] rem,
                                             input logic [DenW-1:0] den,
                                             input logic [2:0] sh);
    logic [NumW-1:0] dsh;
    logic [NumW:0] res;
    dsh = NumW'(den) << sh;
    if (rem >= dsh) begin
      res = {1'b1, rem - dsh};
    end else begin
      res = {1'b0, rem};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/hsl_front.sv =====
// front stages: max/min and sector, then hue and saturation terms, then dividends
// depends on hsl_pkg
`default_nettype none

module hsl_front
  import hsl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ChanW-1:0] red,
  input  wire logic [ChanW-1:0] green,
  input  wire logic [ChanW-1:0] blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output div_t                  out_data
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  // stage 1 registers
  sector_t          sec1;
  logic [ChanW-1:0] delta1;
  logic [ChanW:0]   sum1;
  logic signed [ChanW+1:0] diff1;

  // stage 2 registers
  logic [TermW-1:0] term2;
  logic [ChanW-1:0] delta2;
  logic [NumW-1:0]  snum2;
  logic [DenW-1:0]  sden2;
  logic [ChanW-1:0] light2;
  logic             grey2;

  // stage 1 logic
  logic [ChanW-1:0] mx, mn;
  sector_t          sec_c;
  logic signed [ChanW+1:0] diff_c;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    priority if (red == mx) begin
      sec_c  = SEC_RED;
      diff_c = $signed({2'b00, green}) - $signed({2'b00, blue});
    end else if (green == mx) begin
      sec_c  = SEC_GREEN;
      diff_c = $signed({2'b00, blue}) - $signed({2'b00, red});
    end else begin
      sec_c  = SEC_BLUE;
      diff_c = $signed({2'b00, red}) - $signed({2'b00, green});
    end
  end

  // stage 2 logic
  logic signed [TermW+1:0] base_c, t_c;
  logic [ChanW-1:0] den_c;

  always_comb begin
    unique case (sec1)
      SEC_RED:   base_c = '0;
      SEC_GREEN: base_c = $signed({4'b0000, delta1, 1'b0});
      SEC_BLUE:  base_c = $signed({3'b000, delta1, 2'b00});
      default:   base_c = '0;
    endcase
    t_c = base_c + (TermW+2)'(diff1);
    if (t_c < 0) begin
      t_c = t_c + $signed({3'b000, delta1, 2'b00}) + $signed({4'b0000, delta1, 1'b0});
    end
    if (sum1 <= (ChanW+1)'(255)) begin
      den_c = sum1[ChanW-1:0];
    end else begin
      den_c = ChanW'((ChanW+1)'(511) - sum1);
    end
  end

  always_comb begin
    en3 = !v3 || out_ready;
    en2 = !v2 || en3;
    en1 = !v1 || en2;
  end

  assign in_ready  = en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
    if (en1) begin
      sec1   <= sec_c;
      delta1 <= mx - mn;
      sum1   <= {1'b0, mx} + {1'b0, mn};
      diff1  <= diff_c;
    end
    if (en2) begin
      term2  <= t_c[TermW-1:0];
      delta2 <= delta1;
      snum2  <= NumW'(delta1) * NumW'(510) + NumW'(den_c);
      sden2  <= {den_c, 1'b0};
      light2 <= ChanW'((sum1 + (ChanW+1)'(1)) >> 1);
      grey2  <= (delta1 == '0);
    end
    if (en3) begin
      out_data.hrem  <= NumW'(term2) * NumW'(85) + NumW'(delta2);
      out_data.hden  <= {delta2, 1'b0};
      out_data.hq    <= '0;
      out_data.srem  <= snum2;
      out_data.sden  <= sden2;
      out_data.sq    <= '0;
      out_data.grey  <= grey2;
      out_data.light <= light2;
    end
  end

endmodule

`default_nettype wire

// ===== design/hsl_div.sv =====
// pipelined restoring divider, two quotient bits per stage, hue and saturation side by side
// depends on hsl_pkg
`default_nettype none

module hsl_div
  import hsl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  div_t      in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output div_t      out_data
);

  div_t st [DivStg];
  div_t nxt [DivStg];
  logic [DivStg-1:0] v;
  logic [DivStg-1:0] en;

  always_comb begin
    en[DivStg-1] = !v[DivStg-1] || out_ready;
    for (int i = DivStg - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_comb begin
    div_t src;
    logic [NumW:0] h0, h1, s0, s1;
    for (int k = 0; k < DivStg; k++) begin
      src = (k == 0) ? in_data : st[(k == 0) ? 0 : k - 1];
      h0 = div_step(src.hrem, src.hden, 3'(ChanW - 1 - BitsPerStg * k));
      h1 = div_step(h0[NumW-1:0], src.hden, 3'(ChanW - 2 - BitsPerStg * k));
      s0 = div_step(src.srem, src.sden, 3'(ChanW - 1 - BitsPerStg * k));
      s1 = div_step(s0[NumW-1:0], src.sden, 3'(ChanW - 2 - BitsPerStg * k));
      nxt[k] = src;
      nxt[k].hrem = h1[NumW-1:0];
      nxt[k].hq   = {src.hq[ChanW-3:0], h0[NumW], h1[NumW]};
      nxt[k].srem = s1[NumW-1:0];
      nxt[k].sq   = {src.sq[ChanW-3:0], s0[NumW], s1[NumW]};
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[DivStg-1];
  assign out_data  = st[DivStg-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < DivStg; k++) begin
        if (en[k]) v[k] <= (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
      end
    end
    for (int k = 0; k < DivStg; k++) begin
      if (en[k]) st[k] <= nxt[k];
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb_to_hsl_converter.sv =====
// rgb to hsl converter top level: front stages followed by the divider pipeline
// depends on hsl_pkg, hsl_front, hsl_div
// pipeline: 3 front stages, then 4 divider stages, from input transfer to output transfer
// throughput: one pixel per cycle unless held by backpressure; each stage holds under backpressure and bubbles collapse
// reset clears the valid bits of every stage; data registers are not reset
`default_nettype none

module rgb_to_hsl_converter
  import hsl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // hue_out [7:0], saturation_out [15:8], lightness_out [23:16]
);

  logic front_valid, front_ready;
  div_t front_data, div_data;

  hsl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  hsl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (div_data)
  );

  // grey pixels give zero hue and saturation
  assign m_tdata = {div_data.light,
                    div_data.grey ? ChanW'(0) : div_data.sq,
                    div_data.grey ? ChanW'(0) : div_data.hq};

endmodule

`default_nettype wire
